/* rtl/core/assert_macros.svh */
// -----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk and disabled while arst_n is low
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge out of reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a sampled edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/lgge_pkg.sv */
// -----------------------------------------------------------------------------
// lgge_pkg
// shared types and constants of the life grid generation engine
// -----------------------------------------------------------------------------
package lgge_pkg;

	localparam int GRID_SIZE_DEF = 8;

	// request layout
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 3;
	localparam int IO_ROW_W = 8;
	localparam int IN_TDATA_W = 16;

	// neighbor count of one cell, up to eight
	localparam int NBR_W = 4;
	localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
	localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

	// result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PRIME,
		ST_ROW
	} state_t;

endpackage

/* rtl/core/lgge_row_unit.sv */
// -----------------------------------------------------------------------------
// lgge_row_unit
// next generation of one grid row from the old rows above, at and below it
// -----------------------------------------------------------------------------
module lgge_row_unit
	import lgge_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic [GRID_SIZE-1:0] up_row,
	input  logic [GRID_SIZE-1:0] mid_row,
	input  logic [GRID_SIZE-1:0] dn_row,
	output logic [GRID_SIZE-1:0] new_row
);

	logic [GRID_SIZE+1:0] up_p;
	logic [GRID_SIZE+1:0] mid_p;
	logic [GRID_SIZE+1:0] dn_p;
	logic [NBR_W-1:0]     nbr_cnt [GRID_SIZE];

	// dead cells padded in beyond both borders
	assign up_p  = {1'b0, up_row, 1'b0};
	assign mid_p = {1'b0, mid_row, 1'b0};
	assign dn_p  = {1'b0, dn_row, 1'b0};

	always_comb begin
		for (int c = 0; c < GRID_SIZE; c++) begin
			nbr_cnt[c] = NBR_W'(up_p[c]) + NBR_W'(up_p[c+1]) + NBR_W'(up_p[c+2])
				+ NBR_W'(mid_p[c]) + NBR_W'(mid_p[c+2])
				+ NBR_W'(dn_p[c]) + NBR_W'(dn_p[c+1]) + NBR_W'(dn_p[c+2]);
			new_row[c] = (nbr_cnt[c] == BIRTH_COUNT)
				|| ((nbr_cnt[c] == SURVIVE_COUNT) && mid_row[c]);
		end
	end

endmodule

/* rtl/core/lgge_grid_mem.sv */
// -----------------------------------------------------------------------------
// lgge_grid_mem
// grid row memory, one write and one registered read per cycle, rows read
// as dead until first written after reset
// -----------------------------------------------------------------------------
module lgge_grid_mem
	import lgge_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int AW        = $clog2(GRID_SIZE)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [GRID_SIZE-1:0] wr_row,
	input  logic [AW-1:0]        rd_addr,
	output logic [GRID_SIZE-1:0] rd_row
);

	logic [GRID_SIZE-1:0] mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] vld_q;
	logic [GRID_SIZE-1:0] rd_row_q;
	logic                 rd_hit;

	assign rd_hit = ((AW+1)'(rd_addr) < (AW+1)'(GRID_SIZE)) && vld_q[rd_addr];
	assign rd_row = rd_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		rd_row_q <= rd_hit ? mem[rd_addr] : '0;
	end

endmodule

/* rtl/core/life_grid_generation_engine_core.sv */
// -----------------------------------------------------------------------------
// life_grid_generation_engine_core
// conway life (b3/s23) engine on a bounded square grid held as row words
// -----------------------------------------------------------------------------
// The grid is GRID_SIZE x GRID_SIZE cells kept one row per word in a small
// memory, all dead after reset, with dead cells beyond the border (no wrap).
// A write request loads one row and returns nothing. A read request goes
// through the read state (one registered memory read) and returns the row,
// columns 0 to 7, or zero for a row beyond the grid. A step request fetches
// the top row when it is taken, the prime state primes
// the row window, then the shared row unit computes one new row per cycle
// while a three-row window (above, at, below) walks down the grid; the memory
// read port fetching the row below sets that pace. The old rows needed later
// are held in the window, so rows are rewritten in place. A step returns one
// result with zero data. Unknown commands are dropped. Requests are taken one
// at a time; the result sits in an output register, and a new request is taken
// only once that register is empty or drains in the same cycle.
`include "assert_macros.svh"

module life_grid_generation_engine_core
	import lgge_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // row_index[2:0], row_bits[10:3], zero pad
	input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [IO_ROW_W-1:0]   m_axis_tdata,  // row_data[7:0]
	output logic                  m_axis_tuser   // result_kind[0]
);

	localparam int AW    = $clog2(GRID_SIZE);
	localparam int EXT_W = (AW > IDX_W) ? AW : IDX_W;

	// request fields
	cmd_t                 in_cmd;
	logic [IDX_W-1:0]     in_idx;
	logic [IO_ROW_W-1:0]  in_bits;
	logic [EXT_W-1:0]     idx_ext;
	logic [AW-1:0]        idx_addr;
	logic                 idx_hit;
	logic                 in_acc;

	// sequencer
	state_t               state_q;
	state_t               state_d;
	logic [AW-1:0]        row_q;
	logic                 last_row;
	logic                 out_free;
	logic                 out_set_read;
	logic                 out_set_step;

	// row window and memory ports
	logic [GRID_SIZE-1:0] up_q;
	logic [GRID_SIZE-1:0] mid_q;
	logic [GRID_SIZE-1:0] dn_row;
	logic [GRID_SIZE-1:0] new_row;
	logic [GRID_SIZE-1:0] rd_row;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [GRID_SIZE-1:0] wr_row;
	logic [AW-1:0]        rd_addr;
	logic                 read_hit_q;

	// result register
	logic                 out_valid_q;
	logic [IO_ROW_W-1:0]  out_data_q;
	logic                 out_kind_q;

	// assertion terms
	logic                 step_last;
	logic                 step_res_ok;
	logic                 row_past;

	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_idx   = s_axis_tdata[IDX_W-1:0];
	assign in_bits  = s_axis_tdata[IDX_W+IO_ROW_W-1:IDX_W];
	assign idx_ext  = EXT_W'(in_idx);
	assign idx_addr = idx_ext[AW-1:0];
	assign idx_hit  = (EXT_W+1)'(idx_ext) < (EXT_W+1)'(GRID_SIZE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	// result register is free now or drains at this edge
	assign out_free = !out_valid_q || m_axis_tready;
	assign last_row = row_q == AW'(GRID_SIZE - 1);

	// bottom row sees dead cells below
	assign dn_row = last_row ? '0 : rd_row;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	assign step_last   = (state_q == ST_ROW) && last_row;
	assign step_res_ok = m_axis_tvalid && (m_axis_tuser == KIND_STEP) && (m_axis_tdata == '0);
	assign row_past    = (AW+1)'(row_q) >= (AW+1)'(GRID_SIZE);

	lgge_grid_mem #(
		.GRID_SIZE (GRID_SIZE),
		.AW        (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row),
		.rd_addr (rd_addr),
		.rd_row  (rd_row)
	);

	lgge_row_unit #(
		.GRID_SIZE (GRID_SIZE)
	) u_row (
		.up_row  (up_q),
		.mid_row (mid_q),
		.dn_row  (dn_row),
		.new_row (new_row)
	);

	// next state, input ready, memory port control, result triggers
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = idx_addr;
		wr_row        = GRID_SIZE'(in_bits);
		rd_addr       = idx_addr;
		out_set_read  = 1'b0;
		out_set_step  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = out_free;
				if (in_acc) begin
					case (in_cmd)
						CMD_WRITE: begin
							wr_en = idx_hit;
						end
						CMD_STEP: begin
							// fetch the top row for the window
							rd_addr = '0;
							state_d = ST_PRIME;
						end
						CMD_READ: begin
							state_d = ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				out_set_read = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_PRIME: begin
				// top row arrives, fetch the second
				rd_addr = AW'(1);
				state_d = ST_ROW;
			end
			ST_ROW: begin
				// write row r in place, fetch row r+2 (ignored past the end)
				wr_en   = 1'b1;
				wr_addr = row_q;
				wr_row  = new_row;
				rd_addr = row_q + AW'(2);
				if (last_row) begin
					out_set_step = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PRIME) begin
				row_q <= '0;
			end else if (state_q == ST_ROW) begin
				row_q <= row_q + AW'(1);
			end
			if (out_set_read || out_set_step) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// window and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			read_hit_q <= idx_hit;
		end
		if (state_q == ST_PRIME) begin
			up_q  <= '0;
			mid_q <= rd_row;
		end else if (state_q == ST_ROW) begin
			up_q  <= mid_q;
			mid_q <= dn_row;
		end
		if (out_set_read) begin
			out_data_q <= read_hit_q ? IO_ROW_W'(rd_row) : '0;
			out_kind_q <= KIND_READ;
		end else if (out_set_step) begin
			out_data_q <= '0;
			out_kind_q <= KIND_STEP;
		end
	end

	// no request taken while a read or step is in flight
	`ASSERT_NEVER(a_busy_not_ready, (state_q != ST_IDLE) && s_axis_tready, "ready while busy")

	// last row of a step posts a step result with zero data
	`ASSERT_CLK(a_step_result, step_last |=> step_res_ok, "step result missing")

	// an accepted read lands in the read state
	`ASSERT_CLK(a_read_seq, in_acc && (in_cmd == CMD_READ) |=> (state_q == ST_READ), "read not sequenced")

	// row walk stays inside the grid
	`ASSERT_NEVER(a_row_range, (state_q == ST_ROW) && row_past, "row past grid")

endmodule

/* test/lgge_row_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lgge_row_checker
// watches both streams of the life engine, keeps a shadow grid and checks results
// -----------------------------------------------------------------------------
// Every write or step taken on the input stream updates a private copy of the grid.
// Steps and reads queue the result they must produce. Every result taken on
// the output stream is compared with the oldest queued one.
module lgge_row_checker
	import lgge_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // row_index[2:0], row_bits[10:3], zero pad
	input  logic [CMD_W-1:0]      s_axis_tuser,   // cmd[1:0]
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [IO_ROW_W-1:0]   m_axis_tdata,   // row_data[7:0]
	input  logic                  m_axis_tuser,   // result_kind[0]
	output int                    mismatches,
	output int                    outstanding,
	output int                    checked
);

	localparam int GRID = GRID_SIZE_DEF;

	typedef logic [GRID-1:0][GRID-1:0] grid_t;

	typedef struct packed {
		logic [IO_ROW_W-1:0] row_data;
		logic                kind;
	} row_result_t;

	grid_t         shadow_grid;
	row_result_t   awaited_rows[$];
	row_result_t   want;
	row_result_t   got;
	logic [IDX_W-1:0]    req_idx;
	logic [IO_ROW_W-1:0] req_bits;
	int            fail_count;
	int            checked_count;

	// one b3/s23 generation, dead cells beyond the border
	function automatic grid_t next_generation(input grid_t old_grid);
		grid_t fresh;
		int    cnt;
		int    rr;
		int    cc;
		logic  alive;
		fresh = '0;
		for (int r = 0; r < GRID; r++) begin
			for (int c = 0; c < GRID; c++) begin
				cnt = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID && cc >= 0 && cc < GRID)
							cnt += old_grid[rr][cc];
					end
				end
				alive = old_grid[r][c];
				if (cnt == int'(BIRTH_COUNT))
					alive = 1'b1;
				else if (cnt != int'(SURVIVE_COUNT))
					alive = 1'b0;
				fresh[r][c] = alive;
			end
		end
		return fresh;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_grid = '0;
			awaited_rows.delete();
			fail_count = 0;
			checked_count = 0;
			mismatches <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				req_idx  = s_axis_tdata[IDX_W-1:0];
				req_bits = s_axis_tdata[IDX_W +: IO_ROW_W];
				case (s_axis_tuser)
					CMD_WRITE: begin
						if (int'(req_idx) < GRID)
							shadow_grid[req_idx] = req_bits[GRID-1:0];
					end
					CMD_STEP: begin
						shadow_grid = next_generation(shadow_grid);
						awaited_rows.push_back('{row_data: '0, kind: KIND_STEP});
					end
					CMD_READ: begin
						awaited_rows.push_back('{
							row_data: (int'(req_idx) < GRID) ? shadow_grid[req_idx] : '0,
							kind: KIND_READ});
					end
					default: ;  // unknown command, dropped by the block
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{row_data: m_axis_tdata, kind: m_axis_tuser};
				if (awaited_rows.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result row_data %02h kind %0d",
							$realtime, got.row_data, got.kind);
				end else begin
					want = awaited_rows.pop_front();
					checked_count++;
					if (want.row_data !== got.row_data || want.kind !== got.kind) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch, expected row_data %02h kind %0d, got row_data %02h kind %0d",
								$realtime, want.row_data, want.kind, got.row_data, got.kind);
					end
				end
			end
			mismatches <= fail_count;
			outstanding <= awaited_rows.size();
			checked <= checked_count;
		end
	end

endmodule

/* test/tb_life_grid_generation_engine_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_life_grid_generation_engine_core
// stream-level test of the life engine: row writes, generation steps, row reads
// -----------------------------------------------------------------------------
// A directed opening hits reset contents, border rows and columns, all-alive
// and all-dead rows, dropped commands and back-to-back steps. Then random
// episodes load a pattern of chosen density, run a few generations and read
// rows back. Both streams stall in random bursts; the last stretch runs
// without stalls. A separate checker predicts and compares every result.
module tb_life_grid_generation_engine_core;
	import lgge_pkg::*;

	localparam int GRID = GRID_SIZE_DEF;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CALM_TAIL = 150;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {
		FILL_SPARSE,
		FILL_HALF,
		FILL_DENSE,
		FILL_EXTREME
	} fill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // row_index[2:0], row_bits[10:3], zero pad
	logic [CMD_W-1:0]      s_axis_tuser = '0;   // cmd[1:0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [IO_ROW_W-1:0]   m_axis_tdata;        // row_data[7:0]
	logic                  m_axis_tuser;        // result_kind[0]

	int failures;
	int pending;
	int results_checked;

	bit idling_on = 1'b1;
	bit sender_gaps = 1'b1;
	int sent = 0;
	int n_writes = 0;
	int n_steps = 0;
	int n_reads = 0;
	int n_unknown = 0;

	always #2 clk = ~clk;

	life_grid_generation_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lgge_row_checker row_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (failures),
		.outstanding   (pending),
		.checked       (results_checked)
	);

	// present one request and hold it until the block takes it
	task automatic push_request(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [IO_ROW_W-1:0] bits);
		if (idling_on && sender_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'({bits, idx});
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		case (op)
			CMD_WRITE: n_writes++;
			CMD_STEP:  n_steps++;
			CMD_READ:  n_reads++;
			default:   n_unknown++;
		endcase
	endtask

	// drop valid and hold off until every queued result has been seen
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [IO_ROW_W-1:0] random_row(input fill_t fill);
		case (fill)
			FILL_SPARSE:  return IO_ROW_W'($urandom & $urandom);
			FILL_HALF:    return IO_ROW_W'($urandom);
			FILL_DENSE:   return IO_ROW_W'($urandom | $urandom);
			default:      return ($urandom_range(0, 1) == 1) ? '1 : '0;
		endcase
	endfunction

	// result side: stall bursts followed by runs of ready
	initial begin : result_sink
		int stall_left;
		int ready_run;
		stall_left = 0;
		ready_run = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0 && idling_on) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (ready_run == 0 && idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				ready_run = $urandom_range(0, 20);
				m_axis_tready <= 1'b0;
			end else begin
				if (ready_run > 0)
					ready_run--;
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		fill_t fill;
		int    episodes;
		int    gens;
		int    total;
		bit    drained_once;
		total = 0;
		episodes = 0;
		drained_once = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset contents and a step on an empty grid
		push_request(CMD_READ, 3'd0, 8'h00);
		push_request(CMD_READ, 3'd7, 8'hFF);
		push_request(CMD_STEP, 3'd0, 8'h00);
		// border rows full, only the border columns set in a middle row
		push_request(CMD_WRITE, 3'd0, 8'hFF);
		push_request(CMD_WRITE, 3'd7, 8'hFF);
		push_request(CMD_WRITE, 3'd3, 8'h81);
		push_request(CMD_WRITE, 3'd4, 8'h00);
		// unknown command with all fields at both extremes
		push_request(CMD_UNUSED, 3'd7, 8'hFF);
		push_request(CMD_UNUSED, 3'd0, 8'h00);
		push_request(CMD_READ, 3'd0, 8'h00);
		push_request(CMD_READ, 3'd3, 8'h00);
		push_request(CMD_READ, 3'd7, 8'h00);
		push_request(CMD_STEP, 3'd7, 8'hFF);
		push_request(CMD_READ, 3'd0, 8'h00);
		push_request(CMD_READ, 3'd1, 8'h00);
		push_request(CMD_READ, 3'd6, 8'h00);
		push_request(CMD_READ, 3'd7, 8'h00);
		// checkerboard rows, then two steps in a row
		push_request(CMD_WRITE, 3'd5, 8'h55);
		push_request(CMD_WRITE, 3'd2, 8'hAA);
		push_request(CMD_STEP, 3'd0, 8'h00);
		push_request(CMD_STEP, 3'd0, 8'h00);
		push_request(CMD_READ, 3'd2, 8'h00);
		push_request(CMD_READ, 3'd5, 8'h00);
		push_request(CMD_READ, 3'd4, 8'h00);

		total = sent + RANDOM_ITEMS;
		while (sent < total) begin
			episodes++;
			if (sent >= total - CALM_TAIL)
				idling_on = 1'b0;
			sender_gaps = ($urandom_range(0, 3) != 0);
			fill = fill_t'($urandom_range(0, 3));

			// load a pattern: usually the whole grid, sometimes a few rows
			if ($urandom_range(0, 3) != 0) begin
				for (int r = 0; r < GRID; r++)
					push_request(CMD_WRITE, IDX_W'(r), random_row(fill));
			end else begin
				repeat ($urandom_range(1, 4))
					push_request(CMD_WRITE, IDX_W'($urandom_range(0, GRID - 1)),
						random_row(fill));
			end

			if ($urandom_range(0, 5) == 0)
				push_request(CMD_UNUSED, IDX_W'($urandom), IO_ROW_W'($urandom));

			gens = $urandom_range(1, 6);
			repeat (gens) begin
				push_request(CMD_STEP, IDX_W'($urandom), IO_ROW_W'($urandom));
				if ($urandom_range(0, 1) == 0) begin
					for (int r = 0; r < GRID; r++)
						push_request(CMD_READ, IDX_W'(r), IO_ROW_W'($urandom));
				end else begin
					repeat ($urandom_range(1, 3))
						push_request(CMD_READ, IDX_W'($urandom), IO_ROW_W'($urandom));
				end
				// stray write between generations
				if ($urandom_range(0, 7) == 0)
					push_request(CMD_WRITE, IDX_W'($urandom), random_row(fill));
			end

			// once, about halfway, let the block run completely dry
			if (!drained_once && sent >= total - RANDOM_ITEMS / 2) begin
				wait_for_results();
				drained_once = 1'b1;
			end
		end

		wait_for_results();
		repeat (GRID + 4) @(posedge clk);

		$display("covered %0d requests: %0d row writes, %0d steps, %0d row reads, %0d unknown",
			sent, n_writes, n_steps, n_reads, n_unknown);
		$display("%0d results checked over %0d random grid patterns", results_checked, episodes);
		if (failures == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lgge_pkg.sv
rtl/core/lgge_row_unit.sv
rtl/core/lgge_grid_mem.sv
rtl/core/life_grid_generation_engine_core.sv
test/lgge_row_checker.sv
test/tb_life_grid_generation_engine_core.sv
